// File: sv/bdlp_pkg.sv
// shared types and constants for the button debounce block
package bdlp_pkg;

  // default number of buttons
  localparam int unsigned NumButtonsDef = 4;
  // buttons visible in the 4-bit item fields
  localparam int unsigned PinWidth      = 4;
  localparam int unsigned IndexWidth    = 2;
  localparam int unsigned HoldWidth     = 16;
  localparam int unsigned CfgDataWidth  = 16;
  localparam int unsigned CfgIdxWidth   = 1;

  // reset values of the registers
  localparam logic [HoldWidth-1:0] HoldTicksRst    = 16'd100;
  localparam logic                 PressedLevelRst = 1'b0;

  // command codes
  localparam logic CMD_SCAN = 1'b0;
  localparam logic CMD_READ = 1'b1;

  // register indexes
  localparam logic [CfgIdxWidth-1:0] REG_HOLD_TICKS    = 1'b0;
  localparam logic [CfgIdxWidth-1:0] REG_PRESSED_LEVEL = 1'b1;

  typedef struct packed {
    logic                  cmd;
    logic [PinWidth-1:0]   pin_levels;
    logic [IndexWidth-1:0] button_index;
  } in_item_t;

  typedef struct packed {
    logic                flag_read;
    logic [PinWidth-1:0] event_mask;
    logic [PinWidth-1:0] stable_levels;
  } out_item_t;

  // per-button status handed from a lane to the merge stage
  typedef struct packed {
    logic hit;        // flag raised by the current scan transfer
    logic stable_nx;  // debounced level after the current transfer
    logic flag;       // press flag before the current transfer
  } bdlp_lane_t;

endpackage

// File: sv/bdlp_lane.sv
// one button lane: sample history, debounce, press state machine, repeat counter
module bdlp_lane
  import bdlp_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 scan_i,
  input  logic                 clr_i,
  input  logic                 raw_i,
  input  logic                 pressed_level_i,
  input  logic [HoldWidth-1:0] hold_ticks_i,
  output bdlp_lane_t           status_o
);

  typedef enum logic [1:0] {
    ST_INIT,
    ST_RELEASED,
    ST_PRESSED,
    ST_LONG
  } mode_e;

  mode_e                mode_q, mode_d;
  logic [2:0]           hist_q, hist_d;
  logic                 stable_q, stable_d;
  logic                 flag_q, flag_d;
  logic [HoldWidth-1:0] cnt_q, cnt_d;
  logic [HoldWidth-1:0] cnt_dec;
  logic                 agree;
  logic                 pressed;
  logic                 expire;
  logic                 hit;

  assign cnt_dec = cnt_q - HoldWidth'(1);
  assign expire  = (cnt_dec == '0);
  assign agree   = (hist_d == 3'b000) || (hist_d == 3'b111);
  assign pressed = (raw_i == pressed_level_i);

  // next state of the lane
  always_comb begin
    mode_d   = mode_q;
    hist_d   = {hist_q[1:0], raw_i};
    stable_d = stable_q;
    flag_d   = flag_q;
    cnt_d    = cnt_q;
    hit      = 1'b0;
    if (!scan_i) begin
      hist_d = hist_q;
    end
    if (scan_i && agree) begin
      stable_d = raw_i;
      case (mode_q)
        ST_INIT: begin
          mode_d = ST_RELEASED;
        end
        ST_RELEASED: begin
          if (pressed) begin
            flag_d = 1'b1;
            hit    = 1'b1;
            cnt_d  = hold_ticks_i;
            mode_d = ST_PRESSED;
          end
        end
        ST_PRESSED, ST_LONG: begin
          if (!pressed) begin
            mode_d = ST_RELEASED;
          end else if (expire) begin
            flag_d = 1'b1;
            hit    = 1'b1;
            cnt_d  = hold_ticks_i;
            mode_d = ST_LONG;
          end else begin
            cnt_d = cnt_dec;
          end
        end
        default: begin
          mode_d = ST_INIT;
        end
      endcase
    end
    // read transfer clears the flag
    if (clr_i) begin
      flag_d = 1'b0;
    end
  end

  // lane state; released level at reset is the inverse of the default pressed level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= ST_INIT;
      hist_q   <= {3{~PressedLevelRst}};
      stable_q <= ~PressedLevelRst;
      flag_q   <= 1'b0;
      cnt_q    <= HoldTicksRst;
    end else begin
      mode_q   <= mode_d;
      hist_q   <= hist_d;
      stable_q <= stable_d;
      flag_q   <= flag_d;
      cnt_q    <= cnt_d;
    end
  end

  assign status_o.hit       = hit;
  assign status_o.stable_nx = stable_d;
  assign status_o.flag      = flag_q;

endmodule

// File: sv/bdlp_merge.sv
// merges lane status into one result and holds it in the output register
module bdlp_merge
  import bdlp_pkg::*;
#(
  parameter int unsigned NumButtons = NumButtonsDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       accept_i,
  input  in_item_t   item_i,
  input  bdlp_lane_t lane_i [NumButtons],
  input  logic       out_ready_i,
  output logic       out_valid_o,
  output out_item_t  out_data_o,
  output logic       load_ok_o
);

  localparam int unsigned OutLanes = (NumButtons < PinWidth) ? NumButtons : PinWidth;

  out_item_t res;
  logic      valid_q;
  out_item_t data_q;

  // combine what the lanes found
  always_comb begin
    res = '0;
    for (int i = 0; i < OutLanes; i++) begin
      res.stable_levels[i] = lane_i[i].stable_nx;
      if (item_i.cmd == CMD_SCAN) begin
        res.event_mask[i] = lane_i[i].hit;
      end else if (item_i.button_index == IndexWidth'(i)) begin
        res.flag_read = lane_i[i].flag;
      end
    end
  end

  // output register may load when empty or when its item leaves
  assign load_ok_o = !valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_ok_o) begin
      valid_q <= accept_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      data_q <= res;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule

// File: sv/button_debounce_long_press_top.sv
// top level of the button debounce with long press and repeat
//
//   channel | direction | signals                          | payload
//   in      | input     | in_valid_i / in_ready_o          | in_data_i (in_item_t)
//   out     | output    | out_valid_o / out_ready_i        | out_data_o (out_item_t)
//   cfg     | input     | cfg_we_i, cfg_idx_i, cfg_wdata_i | hold_ticks, pressed_level
//
// one item per cycle while in_ready_o is high: every button lane updates in the cycle of
// the transfer and the merged result appears in the output register in the following cycle.
// in_ready_o is high while the output register is empty or being taken.
// reset: all lanes in init state, history and stable level at the released level.
module button_debounce_long_press_top
  import bdlp_pkg::*;
#(
  parameter int unsigned NumButtons = NumButtonsDef
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  in_item_t                in_data_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output out_item_t               out_data_o,
  input  logic                    cfg_we_i,
  input  logic [CfgIdxWidth-1:0]  cfg_idx_i,
  input  logic [CfgDataWidth-1:0] cfg_wdata_i
);

  logic [HoldWidth-1:0] hold_ticks_q;
  logic                 pressed_level_q;
  logic                 accept;
  logic                 scan;
  logic                 rd;
  bdlp_lane_t           lane [NumButtons];

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_ticks_q    <= HoldTicksRst;
      pressed_level_q <= PressedLevelRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_HOLD_TICKS:    hold_ticks_q    <= cfg_wdata_i[HoldWidth-1:0];
        REG_PRESSED_LEVEL: pressed_level_q <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  assign accept = in_valid_i && in_ready_o;
  assign scan   = accept && (in_data_i.cmd == CMD_SCAN);
  assign rd     = accept && (in_data_i.cmd == CMD_READ);

  // one lane per button
  for (genvar i = 0; i < NumButtons; i++) begin : g_lane
    logic raw;
    logic clr;
    if (i < PinWidth) begin : g_pin
      assign raw = in_data_i.pin_levels[i];
      assign clr = rd && (in_data_i.button_index == IndexWidth'(i));
    end else begin : g_nopin
      assign raw = 1'b0;
      assign clr = 1'b0;
    end
    bdlp_lane u_lane (
      .clk_i           (clk_i),
      .rst_ni          (rst_ni),
      .scan_i          (scan),
      .clr_i           (clr),
      .raw_i           (raw),
      .pressed_level_i (pressed_level_q),
      .hold_ticks_i    (hold_ticks_q),
      .status_o        (lane[i])
    );
  end

  bdlp_merge #(
    .NumButtons (NumButtons)
  ) u_merge (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .item_i      (in_data_i),
    .lane_i      (lane),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o),
    .load_ok_o   (in_ready_o)
  );

endmodule
